// ===== hdl/sphc_pkg.sv =====
package sphc_pkg;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Work handed from the front to the back. A job carries one or two bytes.
  // In hex form each byte leaves as two ASCII digits, otherwise as itself.
  typedef struct packed {
    logic       hex;
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_val_t;

  localparam logic [6:0] SeptetMask = 7'h7F;
  localparam logic [3:0] SeptetBits = 4'd7;
  localparam logic [3:0] OctetBits  = 4'd8;

  function automatic hex_val_t hex_value(input logic [7:0] c);
    hex_val_t r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r.ok  = 1'b1;
      r.val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      r.ok  = 1'b1;
      r.val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      r.ok  = 1'b1;
      r.val = 4'(c - "A" + 8'd10);
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'("0") + {4'b0, n};
    end else begin
      r = 8'("a") + {4'b0, n} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== hdl/sphc_front.sv =====
module sphc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sphc_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output sphc_pkg::job_t     job_o
);

  logic       dir_q, dir_d;
  logic [6:0] acc_q, acc_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] first_q, first_d;
  logic       have_q, have_d;

  logic        accept;
  logic [13:0] comb;
  logic [3:0]  tot;
  logic [7:0]  oct;
  logic [7:0]  mask;
  logic [7:0]  shifted;
  logic [6:0]  sept;
  logic [6:0]  carry;
  logic [3:0]  sh_next;
  sphc_pkg::hex_val_t hi, lo;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    have_d  = have_q;
    dir_d   = dir_q;
    job_o   = '0;
    push_o  = 1'b0;
    comb    = 14'({7'b0, acc_q} | (14'(in_data_i.in_byte[6:0]) << cnt_q));
    tot     = {1'b0, cnt_q} + sphc_pkg::SeptetBits;
    hi      = sphc_pkg::hex_value(first_q);
    lo      = sphc_pkg::hex_value(in_data_i.in_byte);
    if (!hi.ok) begin
      oct = 8'h00;
    end else if (lo.ok) begin
      oct = {hi.val, lo.val};
    end else begin
      oct = {4'b0, hi.val};
    end
    mask    = 8'(sphc_pkg::SeptetMask) >> cnt_q;
    shifted = (oct & mask) << cnt_q;
    sept    = shifted[6:0] | acc_q;
    carry   = 7'(oct >> (3'd7 - cnt_q));
    sh_next = {1'b0, cnt_q} + 4'd1;
    job_o.hex = !dir_q;

    if (cfg_we_i) begin
      dir_d   = cfg_data_i;
      acc_d   = '0;
      cnt_d   = '0;
      first_d = '0;
      have_d  = 1'b0;
    end else if (accept) begin
      if (!dir_q) begin
        // Packing: add seven bits, emit an octet once eight are pending.
        if (tot >= sphc_pkg::OctetBits) begin
          job_o.byte0 = comb[7:0];
          push_o      = 1'b1;
          acc_d       = {1'b0, comb[13:8]};
          cnt_d       = 3'(tot - sphc_pkg::OctetBits);
        end else begin
          acc_d = comb[6:0];
          cnt_d = tot[2:0];
        end
        if (in_data_i.end_of_message) begin
          if (cnt_d != 3'd0) begin
            if (push_o) begin
              job_o.two   = 1'b1;
              job_o.byte1 = {1'b0, acc_d};
            end else begin
              job_o.byte0 = {1'b0, acc_d};
            end
            push_o = 1'b1;
          end
          acc_d = '0;
          cnt_d = '0;
        end
      end else begin
        // Unpacking: the second character of a pair completes an octet.
        if (!have_q) begin
          first_d = in_data_i.in_byte;
          have_d  = 1'b1;
        end else begin
          first_d     = '0;
          have_d      = 1'b0;
          push_o      = 1'b1;
          job_o.byte0 = {1'b0, sept};
          if (sh_next >= sphc_pkg::SeptetBits) begin
            // A seventh octet leaves a whole septet in the carry.
            job_o.two   = 1'b1;
            job_o.byte1 = {1'b0, carry};
            acc_d       = '0;
            cnt_d       = '0;
          end else begin
            acc_d = carry;
            cnt_d = sh_next[2:0];
          end
        end
        if (in_data_i.end_of_message) begin
          acc_d   = '0;
          cnt_d   = '0;
          first_d = '0;
          have_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
      first_q <= '0;
      have_q  <= 1'b0;
    end else begin
      dir_q   <= dir_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      have_q  <= have_d;
    end
  end

endmodule

// ===== hdl/sphc_queue.sv =====
module sphc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sphc_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output sphc_pkg::job_t head_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  sphc_pkg::job_t  slots_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == DepthCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = slots_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into a full queue");
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("job popped from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt) else $error("queue fill count out of range");

endmodule

// ===== hdl/sphc_back.sv =====
module sphc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  sphc_pkg::job_t      head_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sphc_pkg::out_item_t out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic [1:0] last_idx;
  logic       is_last;
  logic       xfer;
  logic [7:0] sel;

  assign last_idx    = head_data_i.hex ? {head_data_i.two, 1'b1} : {1'b0, head_data_i.two};
  assign is_last     = (idx_q == last_idx);
  assign out_valid_o = head_valid_i;
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && is_last;

  always_comb begin
    if (head_data_i.hex) begin
      sel = idx_q[1] ? head_data_i.byte1 : head_data_i.byte0;
      out_data_o.out_byte = sphc_pkg::hex_digit(idx_q[0] ? sel[3:0] : sel[7:4]);
    end else begin
      sel = idx_q[0] ? head_data_i.byte1 : head_data_i.byte0;
      out_data_o.out_byte = sel;
    end
    out_data_o.last_of_run = is_last;
  end

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_mid_job_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> head_valid_i) else $error("result index advanced without a job");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q <= last_idx)) else $error("result index beyond job length");
  a_pop_resets_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0)) else $error("result index not cleared after job");

endmodule

// ===== hdl/septet_pack_hex_codec_top.sv =====
// Streaming 7-bit septet codec. With direction 0 each input transfer adds the
// low seven bits of its character to a bit stream packed LSB first, and every
// finished octet leaves as two lowercase hex digits, high nibble first; an
// item marked end_of_message flushes leftover bits as one more octet. With
// direction 1 input characters are paired into hex octets and unpacked into
// septets, one per octet plus an extra one after every seventh octet. Writing
// direction clears the codec state and must happen only while the block is
// idle. The front classifies an item in the cycle it is accepted and queues
// the resulting bytes; the back emits one result transfer per cycle while
// out_ready_i is high, and the first result of an item follows once earlier
// jobs have left the queue. Throughput is set by that single output byte per
// cycle: packing averages seven eighths of an octet per item, so about 1.75
// hex digits per item, with up to four results on a flushing item.
// Input is held off only while the job queue is full.
module septet_pack_hex_codec_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sphc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sphc_pkg::out_item_t out_data_o
);

  // Jobs move from the front to the back through a small queue, so an
  // input transfer can proceed while earlier results still wait downstream.
  logic           push;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  sphc_pkg::job_t job;
  sphc_pkg::job_t head;

  sphc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  sphc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head)
  );

  // The back walks through the bytes of the head job, one result per cycle while out_ready_i is high.
  sphc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !q_full) else $error("input ready disagrees with queue space");
  a_out_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> head_valid) else $error("result offered without a queued job");
  a_push_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o) else $error("queued job not offered at the output");

endmodule
